// File: hdl/bawf_pkg.sv
package bawf_pkg;

    localparam logic [7:0] BYTE_MAX  = 8'hFF;
    localparam logic [7:0] LOW_SEVEN = 8'h7F;
    localparam logic [7:0] TOP_BIT   = 8'h80;

    // iterations of the shared adder for multiply and divide
    localparam int unsigned ITER_STEPS = 8;
    localparam int unsigned CNT_W      = $clog2(ITER_STEPS);

    // flag store bit positions
    localparam int unsigned F_CF = 0;
    localparam int unsigned F_PF = 1;
    localparam int unsigned F_ZF = 2;
    localparam int unsigned F_SF = 3;
    localparam int unsigned F_OF = 4;

    typedef enum logic [4:0] {
        ACT_ADD  = 5'd0,
        ACT_ADC  = 5'd1,
        ACT_SUB  = 5'd2,
        ACT_SBB  = 5'd3,
        ACT_INC  = 5'd4,
        ACT_DEC  = 5'd5,
        ACT_MUL  = 5'd6,
        ACT_IMUL = 5'd7,
        ACT_DIV  = 5'd8,
        ACT_NEG  = 5'd9,
        ACT_AND  = 5'd10,
        ACT_OR   = 5'd11,
        ACT_XOR  = 5'd12,
        ACT_NOT  = 5'd13,
        ACT_SHL  = 5'd14,
        ACT_SHR  = 5'd15,
        ACT_SAR  = 5'd16
    } t_act;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALU,
        ST_MUL,
        ST_FIXA,
        ST_FIXB,
        ST_DCHK,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_ALU,
        STEP_MUL,
        STEP_FIXA,
        STEP_FIXB,
        STEP_DCHK,
        STEP_DIV,
        STEP_FIN
    } t_step;

    typedef struct packed {
        logic [4:0] action;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [7:0] dividend_high;
    } t_req;

    typedef struct packed {
        logic [7:0] result_low;
        logic [7:0] result_high;
        logic       carry_flag;
        logic       parity_flag;
        logic       zero_flag;
        logic       sign_flag;
        logic       overflow_flag;
        logic       divide_error;
    } t_res;

    typedef struct packed {
        logic  load;
        t_step step;
        logic  fin_write;
    } t_ctl;

    typedef struct packed {
        logic imul;
        logic div_fault;
        logic res_free;
    } t_sts;

endpackage

// File: hdl/bawf_ctrl.sv
module bawf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic [4:0]      i_action,
    input  bawf_pkg::t_sts  i_sts,
    output logic            o_req_stall,
    output bawf_pkg::t_ctl  o_ctl
);

    bawf_pkg::t_state r_state, n_state;
    logic [bawf_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic cnt_last;

    assign cnt_last = (r_cnt == bawf_pkg::CNT_W'(bawf_pkg::ITER_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bawf_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            bawf_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_req_valid) begin
                    if (i_action == bawf_pkg::ACT_MUL || i_action == bawf_pkg::ACT_IMUL) begin
                        n_state = bawf_pkg::ST_MUL;
                    end else if (i_action == bawf_pkg::ACT_DIV) begin
                        n_state = bawf_pkg::ST_DCHK;
                    end else begin
                        n_state = bawf_pkg::ST_ALU;
                    end
                end
            end
            bawf_pkg::ST_ALU: begin
                n_state = bawf_pkg::ST_FIN;
            end
            bawf_pkg::ST_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = i_sts.imul ? bawf_pkg::ST_FIXA : bawf_pkg::ST_FIN;
                end
            end
            bawf_pkg::ST_FIXA: begin
                n_state = bawf_pkg::ST_FIXB;
            end
            bawf_pkg::ST_FIXB: begin
                n_state = bawf_pkg::ST_FIN;
            end
            bawf_pkg::ST_DCHK: begin
                n_state = i_sts.div_fault ? bawf_pkg::ST_FIN : bawf_pkg::ST_DIV;
            end
            bawf_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = bawf_pkg::ST_FIN;
                end
            end
            bawf_pkg::ST_FIN: begin
                // hold until the result register can take the result
                if (i_sts.res_free) begin
                    n_state = bawf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bawf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_req_stall     = 1'b1;
        o_ctl.load      = 1'b0;
        o_ctl.step      = bawf_pkg::STEP_NONE;
        o_ctl.fin_write = 1'b0;
        unique case (r_state)
            bawf_pkg::ST_IDLE: begin
                o_req_stall = 1'b0;
                o_ctl.load  = i_req_valid;
            end
            bawf_pkg::ST_ALU:  o_ctl.step = bawf_pkg::STEP_ALU;
            bawf_pkg::ST_MUL:  o_ctl.step = bawf_pkg::STEP_MUL;
            bawf_pkg::ST_FIXA: o_ctl.step = bawf_pkg::STEP_FIXA;
            bawf_pkg::ST_FIXB: o_ctl.step = bawf_pkg::STEP_FIXB;
            bawf_pkg::ST_DCHK: o_ctl.step = bawf_pkg::STEP_DCHK;
            bawf_pkg::ST_DIV:  o_ctl.step = bawf_pkg::STEP_DIV;
            bawf_pkg::ST_FIN: begin
                o_ctl.step      = bawf_pkg::STEP_FIN;
                o_ctl.fin_write = i_sts.res_free;
            end
            default: begin
                o_ctl.step = bawf_pkg::STEP_NONE;
            end
        endcase
    end

endmodule

// File: hdl/bawf_datapath.sv
module bawf_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bawf_pkg::t_req  i_req,
    input  bawf_pkg::t_ctl  i_ctl,
    input  logic            i_res_stall,
    output bawf_pkg::t_sts  o_sts,
    output logic            o_res_valid,
    output bawf_pkg::t_res  o_res
);

    logic [4:0] r_act;
    logic [7:0] r_a;
    logic [7:0] r_b;
    logic [7:0] r_lo;
    logic [7:0] r_hi;
    logic       r_c;
    logic       r_derr;
    logic [4:0] r_flags, n_flags;
    bawf_pkg::t_res r_res;
    logic       r_res_valid, n_res_valid;

    // shared adder
    logic [8:0] add_x;
    logic [8:0] add_y;
    logic       add_sub;
    logic       add_cin;
    logic [9:0] add_sum;
    logic [8:0] add_y_eff;

    logic [7:0] alu_lo;
    logic       alu_c;
    logic [8:0] div_part;
    logic       pf, zf, sf;
    logic       mul_sig;
    logic [7:0] fin_lo, fin_hi;

    assign div_part  = {r_hi, r_lo[7]};
    assign add_y_eff = add_sub ? ~add_y : add_y;
    assign add_sum   = {1'b0, add_x} + {1'b0, add_y_eff} + {9'd0, add_cin};

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        add_cin = 1'b0;
        unique case (i_ctl.step)
            bawf_pkg::STEP_ALU: begin
                add_x = {1'b0, r_a};
                add_y = {1'b0, r_b};
                case (bawf_pkg::t_act'(r_act))
                    bawf_pkg::ACT_ADC: add_cin = r_flags[bawf_pkg::F_CF];
                    bawf_pkg::ACT_SUB: begin
                        add_sub = 1'b1;
                        add_cin = 1'b1;
                    end
                    bawf_pkg::ACT_SBB: begin
                        add_sub = 1'b1;
                        add_cin = ~r_flags[bawf_pkg::F_CF];
                    end
                    bawf_pkg::ACT_INC: add_y = 9'd1;
                    bawf_pkg::ACT_DEC: begin
                        add_y   = 9'd1;
                        add_sub = 1'b1;
                        add_cin = 1'b1;
                    end
                    bawf_pkg::ACT_NEG: begin
                        add_x   = '0;
                        add_y   = {1'b0, r_a};
                        add_sub = 1'b1;
                        add_cin = 1'b1;
                    end
                    default: add_cin = 1'b0;
                endcase
            end
            bawf_pkg::STEP_MUL: begin
                add_x = {1'b0, r_hi};
                add_y = r_lo[0] ? {1'b0, r_a} : 9'd0;
            end
            bawf_pkg::STEP_FIXA: begin
                // signed correction: drop b from the high byte when a is negative
                add_x   = {1'b0, r_hi};
                add_y   = r_a[7] ? {1'b0, r_b} : 9'd0;
                add_sub = 1'b1;
                add_cin = 1'b1;
            end
            bawf_pkg::STEP_FIXB: begin
                add_x   = {1'b0, r_hi};
                add_y   = r_b[7] ? {1'b0, r_a} : 9'd0;
                add_sub = 1'b1;
                add_cin = 1'b1;
            end
            bawf_pkg::STEP_DCHK: begin
                add_x   = {1'b0, r_hi};
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
                add_cin = 1'b1;
            end
            bawf_pkg::STEP_DIV: begin
                add_x   = div_part;
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
                add_cin = 1'b1;
            end
            bawf_pkg::STEP_NONE, bawf_pkg::STEP_FIN: begin
                add_x = '0;
            end
            default: add_x = '0;
        endcase
    end

    // single-step results
    always_comb begin
        alu_lo = '0;
        alu_c  = add_sub ? ~add_sum[9] : add_sum[8];
        case (bawf_pkg::t_act'(r_act))
            bawf_pkg::ACT_ADD, bawf_pkg::ACT_ADC, bawf_pkg::ACT_SUB, bawf_pkg::ACT_SBB,
            bawf_pkg::ACT_INC, bawf_pkg::ACT_DEC, bawf_pkg::ACT_NEG: alu_lo = add_sum[7:0];
            bawf_pkg::ACT_AND: alu_lo = r_a & r_b;
            bawf_pkg::ACT_OR:  alu_lo = r_a | r_b;
            bawf_pkg::ACT_XOR: alu_lo = r_a ^ r_b;
            bawf_pkg::ACT_NOT: alu_lo = ~r_a;
            bawf_pkg::ACT_SHL: alu_lo = {r_a[6:0], 1'b0};
            bawf_pkg::ACT_SHR: alu_lo = {1'b0, r_a[7:1]};
            bawf_pkg::ACT_SAR: alu_lo = {r_a[7], r_a[7:1]};
            default:           alu_lo = '0;
        endcase
    end

    // final flags
    assign pf = ~(^r_lo);
    assign zf = (r_lo == 8'd0);
    assign sf = r_lo[7];
    assign mul_sig = (r_act == bawf_pkg::ACT_IMUL) ? (r_hi != {8{r_lo[7]}}) : (r_hi != 8'd0);

    always_comb begin
        n_flags = r_flags;
        fin_lo  = r_derr ? 8'd0 : r_lo;
        fin_hi  = r_derr ? 8'd0 : r_hi;
        case (bawf_pkg::t_act'(r_act))
            bawf_pkg::ACT_ADD, bawf_pkg::ACT_ADC: begin
                n_flags[bawf_pkg::F_CF] = r_c;
                n_flags[bawf_pkg::F_OF] = ~(r_a[7] ^ r_b[7]) & (r_a[7] ^ r_lo[7]);
            end
            bawf_pkg::ACT_SUB, bawf_pkg::ACT_SBB: begin
                n_flags[bawf_pkg::F_CF] = r_c;
                n_flags[bawf_pkg::F_OF] = (r_a[7] ^ r_b[7]) & (r_a[7] ^ r_lo[7]);
            end
            bawf_pkg::ACT_INC: n_flags[bawf_pkg::F_OF] = (r_a == bawf_pkg::LOW_SEVEN);
            bawf_pkg::ACT_DEC: n_flags[bawf_pkg::F_OF] = (r_a == bawf_pkg::TOP_BIT);
            bawf_pkg::ACT_NEG: begin
                n_flags[bawf_pkg::F_CF] = r_c;
                n_flags[bawf_pkg::F_OF] = (r_a == bawf_pkg::TOP_BIT);
            end
            bawf_pkg::ACT_MUL, bawf_pkg::ACT_IMUL: begin
                n_flags[bawf_pkg::F_CF] = mul_sig;
                n_flags[bawf_pkg::F_OF] = mul_sig;
            end
            bawf_pkg::ACT_AND, bawf_pkg::ACT_OR, bawf_pkg::ACT_XOR: begin
                n_flags[bawf_pkg::F_CF] = 1'b0;
                n_flags[bawf_pkg::F_OF] = 1'b0;
            end
            bawf_pkg::ACT_SHL: begin
                n_flags[bawf_pkg::F_CF] = r_a[7];
                n_flags[bawf_pkg::F_OF] = r_lo[7] ^ r_a[7];
            end
            bawf_pkg::ACT_SHR: begin
                n_flags[bawf_pkg::F_CF] = r_a[0];
                n_flags[bawf_pkg::F_OF] = r_a[7];
            end
            bawf_pkg::ACT_SAR: begin
                n_flags[bawf_pkg::F_CF] = r_a[0];
                n_flags[bawf_pkg::F_OF] = 1'b0;
            end
            default: n_flags[bawf_pkg::F_CF] = r_flags[bawf_pkg::F_CF];
        endcase
        // result flags for every action that sets them
        if (r_act <= bawf_pkg::ACT_IMUL || r_act == bawf_pkg::ACT_NEG
                || (r_act >= bawf_pkg::ACT_AND && r_act <= bawf_pkg::ACT_XOR)
                || (r_act >= bawf_pkg::ACT_SHL && r_act <= bawf_pkg::ACT_SAR)
                || (r_act == bawf_pkg::ACT_DIV && !r_derr)) begin
            n_flags[bawf_pkg::F_PF] = pf;
            n_flags[bawf_pkg::F_ZF] = zf;
            n_flags[bawf_pkg::F_SF] = sf;
        end
    end

    always_comb begin
        n_res_valid = r_res_valid && i_res_stall;
        if (i_ctl.fin_write) begin
            n_res_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
            if (i_ctl.fin_write) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_act  <= i_req.action;
            r_a    <= i_req.operand_a;
            r_b    <= i_req.operand_b;
            r_derr <= 1'b0;
            r_c    <= 1'b0;
            // multiplier shifts out of the low byte; dividend low shifts out of it too
            r_lo   <= (i_req.action == bawf_pkg::ACT_DIV) ? i_req.operand_a : i_req.operand_b;
            r_hi   <= (i_req.action == bawf_pkg::ACT_DIV) ? i_req.dividend_high : 8'd0;
        end else begin
            unique case (i_ctl.step)
                bawf_pkg::STEP_ALU: begin
                    r_lo <= alu_lo;
                    r_c  <= alu_c;
                end
                bawf_pkg::STEP_MUL: begin
                    r_hi <= add_sum[8:1];
                    r_lo <= {add_sum[0], r_lo[7:1]};
                end
                bawf_pkg::STEP_FIXA, bawf_pkg::STEP_FIXB: begin
                    r_hi <= add_sum[7:0];
                end
                bawf_pkg::STEP_DCHK: begin
                    // high byte not below divisor: zero divisor or quotient overflow
                    r_derr <= add_sum[9];
                end
                bawf_pkg::STEP_DIV: begin
                    r_hi <= add_sum[9] ? add_sum[7:0] : div_part[7:0];
                    r_lo <= {r_lo[6:0], add_sum[9]};
                end
                bawf_pkg::STEP_NONE, bawf_pkg::STEP_FIN: begin
                    r_c <= r_c;
                end
                default: r_c <= r_c;
            endcase
        end
        if (i_ctl.fin_write) begin
            r_res.result_low    <= fin_lo;
            r_res.result_high   <= fin_hi;
            r_res.carry_flag    <= n_flags[bawf_pkg::F_CF];
            r_res.parity_flag   <= n_flags[bawf_pkg::F_PF];
            r_res.zero_flag     <= n_flags[bawf_pkg::F_ZF];
            r_res.sign_flag     <= n_flags[bawf_pkg::F_SF];
            r_res.overflow_flag <= n_flags[bawf_pkg::F_OF];
            r_res.divide_error  <= r_derr;
        end
    end

    assign o_sts.imul      = (r_act == bawf_pkg::ACT_IMUL);
    assign o_sts.div_fault = add_sum[9];
    assign o_sts.res_free  = !r_res_valid || !i_res_stall;
    assign o_res_valid     = r_res_valid;
    assign o_res           = r_res;

endmodule

// File: hdl/byte_alu_with_flags.sv
// States per request: ALU, FIN for single-step actions; DCHK, FIN for a faulting div;
// MUL, FIN for mul; MUL, FIXA, FIXB, FIN for imul; DCHK, DIV, FIN for div.
// One request at a time on the shared 9-bit adder (8 passes for mul and div, 2 more
// for the imul sign fix-up); the next request is taken in the cycle after the result
// loads, and the result loads only once the output register is free (i_res_stall).
// Synchronous active-low reset clears the sequencer, the output valid and the flag store.
module byte_alu_with_flags (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  bawf_pkg::t_req  i_req,
    output logic            o_res_valid,
    input  logic            i_res_stall,
    output bawf_pkg::t_res  o_res
);

    bawf_pkg::t_ctl ctl;
    bawf_pkg::t_sts sts;

    bawf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_action    (i_req.action),
        .i_sts       (sts),
        .o_req_stall (o_req_stall),
        .o_ctl       (ctl)
    );

    bawf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_ctl       (ctl),
        .i_res_stall (i_res_stall),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
